// ----- rtl/lfu_pkg.sv -----
`default_nettype none

package lfu_pkg;

  localparam int unsigned KEY_W      = 31;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned CAP_W      = 5;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // register index is paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  localparam logic FUNC_ACCESS = 1'b0;
  localparam logic FUNC_SYNC   = 1'b1;

  localparam logic [KIND_W-1:0] KIND_HIT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FILL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WB   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DONE = 2'd3;

  typedef struct packed {
    logic load;
    logic scan;
    logic hit_commit;
    logic evict;
    logic fill;
    logic emit_done;
  } lfu_cmd_t;

  typedef struct packed {
    logic sync;
    logic scan_done;
    logic hit;
    logic evict;
    logic victim_dirty;
    logic out_free;
  } lfu_sts_t;

endpackage

`default_nettype wire

// ----- rtl/lfu_req_if.sv -----
`default_nettype none

interface lfu_req_if;
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [lfu_pkg::KEY_W-1:0]  page_key;
  logic                       modify;

  modport source (output valid, func, page_key, modify, input ready);
  modport sink   (input valid, func, page_key, modify, output ready);
endinterface

`default_nettype wire

// ----- rtl/lfu_rsp_if.sv -----
`default_nettype none

interface lfu_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [lfu_pkg::KIND_W-1:0]  kind;
  logic [lfu_pkg::KEY_W-1:0]   out_key;
  logic [lfu_pkg::SLOT_W-1:0]  slot;
  logic                        last;

  modport source (output valid, kind, out_key, slot, last, input ready);
  modport sink   (input valid, kind, out_key, slot, last, output ready);
endinterface

`default_nettype wire

// ----- rtl/lfu_ctrl.sv -----
`default_nettype none

module lfu_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire lfu_pkg::lfu_sts_t sts_i,
  output lfu_pkg::lfu_cmd_t      cmd_o
);
  import lfu_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESOLVE,
    ST_EVICT,
    ST_FILL,
    ST_DONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = sts_i.sync ? ST_DONE : ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        if (!sts_i.hit) begin
          state_d = ST_EVICT;
        end else if (sts_i.out_free) begin
          cmd_o.hit_commit = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_EVICT: begin
        // a dirty victim needs the output register for its writeback
        priority if (!sts_i.evict) begin
          state_d = ST_FILL;
        end else if (!sts_i.victim_dirty || sts_i.out_free) begin
          cmd_o.evict = 1'b1;
          state_d     = ST_FILL;
        end
      end
      ST_FILL: begin
        if (sts_i.out_free) begin
          cmd_o.fill = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit_done = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lfu_dp.sv -----
`default_nettype none

module lfu_dp #(
  parameter int unsigned WAYS       = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [lfu_pkg::CAP_W-1:0]    cap_i,
  input  wire logic                         req_func_i,
  input  wire logic [lfu_pkg::KEY_W-1:0]    req_key_i,
  input  wire logic                         req_modify_i,
  input  wire lfu_pkg::lfu_cmd_t            cmd_i,
  output lfu_pkg::lfu_sts_t                 sts_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [lfu_pkg::KIND_W-1:0]        out_kind_o,
  output logic [lfu_pkg::KEY_W-1:0]         out_key_o,
  output logic [lfu_pkg::SLOT_W-1:0]        out_slot_o,
  output logic                              out_last_o
);
  import lfu_pkg::*;

  localparam int unsigned IDX_W = $clog2(WAYS);
  localparam int unsigned AW    = $clog2(WAYS + 1);
  localparam int unsigned CMP_W = (AW > CAP_W) ? AW : CAP_W;

  // key and count stores: one write port, one registered read port
  logic [KEY_W-1:0]      key_mem [WAYS];
  logic [COUNT_BITS-1:0] cnt_mem [WAYS];
  logic [KEY_W-1:0]      key_rd_q;
  logic [COUNT_BITS-1:0] cnt_rd_q;

  logic [WAYS-1:0] valid_q, valid_d;
  logic [WAYS-1:0] dirty_q, dirty_d;

  logic             func_q;
  logic             modify_q;
  logic [KEY_W-1:0] req_key_q;

  logic [AW-1:0]    rd_addr_q;
  logic             stage_vld_q;
  logic [IDX_W-1:0] stage_idx_q;

  logic                  hit_q;
  logic [IDX_W-1:0]      hit_idx_q;
  logic [COUNT_BITS-1:0] hit_cnt_q;
  logic [AW-1:0]         used_q;
  logic                  vict_vld_q;
  logic [IDX_W-1:0]      vict_idx_q;
  logic [COUNT_BITS-1:0] vict_cnt_q;
  logic [KEY_W-1:0]      vict_key_q;
  logic                  free_vld_q;
  logic [IDX_W-1:0]      free_idx_q;
  logic                  evicted_q;

  logic              out_vld_q;
  logic [KIND_W-1:0] out_kind_q;
  logic [KEY_W-1:0]  out_key_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic              out_last_q;

  logic                  out_free;
  logic                  issue;
  logic                  st_valid;
  logic                  st_dirty;
  logic                  sync_wb;
  logic                  stall;
  logic                  step;
  logic                  rd_en;
  logic                  eval;
  logic [IDX_W-1:0]      fill_idx;
  logic [IDX_W-1:0]      wr_addr;
  logic [COUNT_BITS-1:0] cnt_wr;
  logic [COUNT_BITS-1:0] hit_cnt_inc;
  logic [CMP_W-1:0]      eff_cap;
  logic                  evict_need;
  logic                  emit;
  logic [KIND_W-1:0]     emit_kind;
  logic [KEY_W-1:0]      emit_key;
  logic [IDX_W-1:0]      emit_idx;
  logic                  emit_last;
  logic [SLOT_W+IDX_W-1:0] slot_ext;

  assign out_free = !out_vld_q || out_ready_i;
  assign issue    = rd_addr_q < AW'(WAYS);
  assign st_valid = valid_q[stage_idx_q];
  assign st_dirty = dirty_q[stage_idx_q];

  // a sync scan holds while a dirty slot waits for the output register
  assign sync_wb = cmd_i.scan && (func_q == FUNC_SYNC) && stage_vld_q && st_valid && st_dirty;
  assign stall   = sync_wb && !out_free;
  assign step    = cmd_i.scan && !stall;
  assign rd_en   = step && issue;
  assign eval    = step && stage_vld_q && (func_q == FUNC_ACCESS);

  assign hit_cnt_inc = (&hit_cnt_q) ? hit_cnt_q : hit_cnt_q + 1'b1;

  always_comb begin
    if (cap_i == '0) begin
      eff_cap = CMP_W'(1);
    end else if (CMP_W'(cap_i) > CMP_W'(WAYS)) begin
      eff_cap = CMP_W'(WAYS);
    end else begin
      eff_cap = CMP_W'(cap_i);
    end
  end

  assign evict_need = vict_vld_q && (CMP_W'(used_q) >= eff_cap);

  // lowest free slot once the victim has been released
  always_comb begin
    priority if (evicted_q && (!free_vld_q || vict_idx_q < free_idx_q)) begin
      fill_idx = vict_idx_q;
    end else if (free_vld_q) begin
      fill_idx = free_idx_q;
    end else begin
      fill_idx = '0;
    end
  end

  assign wr_addr = cmd_i.fill ? fill_idx : hit_idx_q;
  assign cnt_wr  = cmd_i.fill ? COUNT_BITS'(1) : hit_cnt_inc;

  always_ff @(posedge clk_i) begin
    if (cmd_i.fill) begin
      key_mem[wr_addr] <= req_key_q;
    end
    if (cmd_i.fill || cmd_i.hit_commit) begin
      cnt_mem[wr_addr] <= cnt_wr;
    end
    if (rd_en) begin
      key_rd_q <= key_mem[rd_addr_q[IDX_W-1:0]];
      cnt_rd_q <= cnt_mem[rd_addr_q[IDX_W-1:0]];
    end
  end

  always_comb begin
    valid_d = valid_q;
    dirty_d = dirty_q;
    if (sync_wb && out_free) begin
      dirty_d[stage_idx_q] = 1'b0;
    end
    if (cmd_i.evict) begin
      valid_d[vict_idx_q] = 1'b0;
      dirty_d[vict_idx_q] = 1'b0;
    end
    if (cmd_i.hit_commit && modify_q) begin
      dirty_d[hit_idx_q] = 1'b1;
    end
    if (cmd_i.fill) begin
      valid_d[fill_idx] = 1'b1;
      dirty_d[fill_idx] = modify_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      dirty_q <= '0;
    end else begin
      valid_q <= valid_d;
      dirty_q <= dirty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q    <= req_func_i;
      req_key_q <= req_key_i;
      modify_q  <= req_modify_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_addr_q   <= '0;
      stage_vld_q <= 1'b0;
      stage_idx_q <= '0;
    end else if (cmd_i.load) begin
      rd_addr_q   <= '0;
      stage_vld_q <= 1'b0;
    end else if (step) begin
      stage_vld_q <= issue;
      if (issue) begin
        rd_addr_q   <= rd_addr_q + 1'b1;
        stage_idx_q <= rd_addr_q[IDX_W-1:0];
      end
    end
  end

  // hit, occupancy, least-count victim and first free slot of the scan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q      <= 1'b0;
      used_q     <= '0;
      vict_vld_q <= 1'b0;
      free_vld_q <= 1'b0;
      evicted_q  <= 1'b0;
    end else if (cmd_i.load) begin
      hit_q      <= 1'b0;
      used_q     <= '0;
      vict_vld_q <= 1'b0;
      free_vld_q <= 1'b0;
      evicted_q  <= 1'b0;
    end else begin
      if (cmd_i.evict) begin
        evicted_q <= 1'b1;
      end
      if (eval) begin
        if (st_valid) begin
          used_q <= used_q + 1'b1;
          if (!hit_q && key_rd_q == req_key_q) begin
            hit_q <= 1'b1;
          end
          if (!vict_vld_q || cnt_rd_q < vict_cnt_q) begin
            vict_vld_q <= 1'b1;
          end
        end else if (!free_vld_q) begin
          free_vld_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (eval && st_valid) begin
      if (!hit_q && key_rd_q == req_key_q) begin
        hit_idx_q <= stage_idx_q;
        hit_cnt_q <= cnt_rd_q;
      end
      if (!vict_vld_q || cnt_rd_q < vict_cnt_q) begin
        vict_idx_q <= stage_idx_q;
        vict_cnt_q <= cnt_rd_q;
        vict_key_q <= key_rd_q;
      end
    end
    if (eval && !st_valid && !free_vld_q) begin
      free_idx_q <= stage_idx_q;
    end
  end

  assign emit = (sync_wb && out_free) || (cmd_i.evict && dirty_q[vict_idx_q]) ||
                cmd_i.hit_commit || cmd_i.fill || cmd_i.emit_done;

  always_comb begin
    priority if (sync_wb) begin
      emit_kind = KIND_WB;
      emit_key  = key_rd_q;
      emit_idx  = stage_idx_q;
      emit_last = 1'b0;
    end else if (cmd_i.evict) begin
      emit_kind = KIND_WB;
      emit_key  = vict_key_q;
      emit_idx  = vict_idx_q;
      emit_last = 1'b0;
    end else if (cmd_i.hit_commit) begin
      emit_kind = KIND_HIT;
      emit_key  = req_key_q;
      emit_idx  = hit_idx_q;
      emit_last = 1'b1;
    end else if (cmd_i.fill) begin
      emit_kind = KIND_FILL;
      emit_key  = req_key_q;
      emit_idx  = fill_idx;
      emit_last = 1'b1;
    end else begin
      emit_kind = KIND_DONE;
      emit_key  = '0;
      emit_idx  = '0;
      emit_last = 1'b1;
    end
  end

  // slot field keeps the low bits of the index
  assign slot_ext = {{SLOT_W{1'b0}}, emit_idx};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_kind_q <= emit_kind;
      out_key_q  <= emit_key;
      out_slot_q <= slot_ext[SLOT_W-1:0];
      out_last_q <= emit_last;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_kind_o  = out_kind_q;
  assign out_key_o   = out_key_q;
  assign out_slot_o  = out_slot_q;
  assign out_last_o  = out_last_q;

  always_comb begin
    sts_o              = '0;
    sts_o.sync         = (func_q == FUNC_SYNC);
    sts_o.scan_done    = !issue && !stage_vld_q;
    sts_o.hit          = hit_q;
    sts_o.evict        = evict_need;
    sts_o.victim_dirty = dirty_q[vict_idx_q];
    sts_o.out_free     = out_free;
  end

endmodule

`default_nettype wire

// ----- rtl/lfu_page_cache_controller_unit.sv -----
`default_nettype none

// Fully associative LFU write-back page directory with WAYS slots. Each request item is
// either a page access or a sync. An access scans every slot, one per cycle through the
// single read port of the key/count store, then answers with a hit, or with an optional
// writeback of the least-used victim (lowest slot on equal counts) followed by a fill
// request. A sync walks all slots the same way, but holds the scan while a dirty page
// waits for the result register; it emits a writeback for each dirty page and ends with
// a done marker. Items are taken one at a time: a new request is accepted only once the
// previous one has finished. The capacity register (byte address 0) limits the occupied
// slots before eviction; 0 acts as 1 and values above WAYS as WAYS. Write it only while
// the block is idle.
module lfu_page_cache_controller_unit #(
  parameter int unsigned WAYS       = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  lfu_req_if.sink                                req_i,
  lfu_rsp_if.source                              rsp_o,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [lfu_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [lfu_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [lfu_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                   pready
);
  import lfu_pkg::*;

  logic [CAP_W-1:0] cap_q;
  lfu_cmd_t         cmd;
  lfu_sts_t         sts;
  logic             in_ready;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_CAPACITY) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_CAPACITY) ? {{(APB_DATA_W-CAP_W){1'b0}}, cap_q} : '0;

  lfu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  assign req_i.ready = in_ready;

  lfu_dp #(
    .WAYS       (WAYS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cap_i        (cap_q),
    .req_func_i   (req_i.func),
    .req_key_i    (req_i.page_key),
    .req_modify_i (req_i.modify),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (rsp_o.valid),
    .out_ready_i  (rsp_o.ready),
    .out_kind_o   (rsp_o.kind),
    .out_key_o    (rsp_o.out_key),
    .out_slot_o   (rsp_o.slot),
    .out_last_o   (rsp_o.last)
  );

endmodule

`default_nettype wire

// ----- sim/lfu_page_cache_controller_unit_checker.sv -----
`default_nettype none

module lfu_page_cache_controller_unit_checker #(
  parameter int unsigned WAYS       = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  lfu_req_if                                  req_i,
  lfu_rsp_if                                  rsp_i,
  input  wire logic                           psel_i,
  input  wire logic                           penable_i,
  input  wire logic                           pwrite_i,
  input  wire logic [lfu_pkg::APB_ADDR_W-1:0] paddr_i,
  input  wire logic [lfu_pkg::APB_DATA_W-1:0] pwdata_i,
  input  wire logic [lfu_pkg::APB_DATA_W-1:0] prdata_i,
  input  wire logic                           pready_i,
  output int                                  errors_o,
  output int                                  pending_o,
  output int                                  hits_o,
  output int                                  fills_o,
  output int                                  writebacks_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [lfu_pkg::KIND_W-1:0] kind;
    logic [lfu_pkg::KEY_W-1:0]  key;
    logic [lfu_pkg::SLOT_W-1:0] slot;
    logic                       last;
  } page_result_t;

  page_result_t                 page_results_q[$];
  logic                         slot_valid[WAYS];
  logic [lfu_pkg::KEY_W-1:0]    slot_key[WAYS];
  logic [COUNT_BITS-1:0]        use_count[WAYS];
  logic                         slot_dirty[WAYS];
  logic [lfu_pkg::CAP_W-1:0]    capacity;

  function automatic int unsigned occupancy_limit();
    if (capacity == '0) return 1;
    if (capacity > WAYS) return WAYS;
    return 32'(capacity);
  endfunction

  function automatic void push_result(input logic [lfu_pkg::KIND_W-1:0] kind,
                                      input logic [lfu_pkg::KEY_W-1:0] key,
                                      input int idx, input logic last);
    page_result_t r;
    r.kind = kind;
    r.key  = key;
    r.slot = idx[lfu_pkg::SLOT_W-1:0];
    r.last = last;
    page_results_q.push_back(r);
  endfunction

  function automatic void predict_directory(input logic func,
                                            input logic [lfu_pkg::KEY_W-1:0] key,
                                            input logic modify);
    int unsigned used;
    int          victim;
    int          free_slot;
    used      = 0;
    victim    = -1;
    free_slot = -1;
    if (func == lfu_pkg::FUNC_SYNC) begin
      for (int i = 0; i < WAYS; i++) begin
        if (slot_valid[i] && slot_dirty[i]) begin
          push_result(lfu_pkg::KIND_WB, slot_key[i], i, 1'b0);
          slot_dirty[i] = 1'b0;
        end
      end
      push_result(lfu_pkg::KIND_DONE, '0, 0, 1'b1);
      return;
    end
    for (int i = 0; i < WAYS; i++) begin
      if (slot_valid[i] && slot_key[i] == key) begin
        if (use_count[i] != '1) use_count[i] = use_count[i] + 1'b1;
        if (modify) slot_dirty[i] = 1'b1;
        push_result(lfu_pkg::KIND_HIT, key, i, 1'b1);
        return;
      end
    end
    // miss: least-used valid slot, lowest index on ties
    for (int i = 0; i < WAYS; i++) begin
      if (slot_valid[i]) begin
        used++;
        if (victim < 0 || use_count[i] < use_count[victim]) victim = i;
      end
    end
    if (used >= occupancy_limit() && victim >= 0) begin
      if (slot_dirty[victim]) push_result(lfu_pkg::KIND_WB, slot_key[victim], victim, 1'b0);
      slot_valid[victim] = 1'b0;
      slot_dirty[victim] = 1'b0;
    end
    for (int i = 0; i < WAYS; i++) begin
      if (!slot_valid[i] && free_slot < 0) free_slot = i;
    end
    if (free_slot < 0) free_slot = 0;
    slot_valid[free_slot] = 1'b1;
    slot_key[free_slot]   = key;
    use_count[free_slot]  = COUNT_BITS'(1);
    slot_dirty[free_slot] = modify;
    push_result(lfu_pkg::KIND_FILL, key, free_slot, 1'b1);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    page_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < WAYS; i++) begin
        slot_valid[i] = 1'b0;
        slot_key[i]   = '0;
        use_count[i]  = '0;
        slot_dirty[i] = 1'b0;
      end
      capacity = lfu_pkg::CAP_RESET;
      page_results_q.delete();
      errors_o     = 0;
      hits_o       = 0;
      fills_o      = 0;
      writebacks_o = 0;
      pending_o   <= 0;
    end else begin
      if (psel_i && penable_i && pready_i && paddr_i[2] == lfu_pkg::REG_CAPACITY) begin
        if (pwrite_i) begin
          capacity = pwdata_i[lfu_pkg::CAP_W-1:0];
        end else if (prdata_i !== {{(lfu_pkg::APB_DATA_W-lfu_pkg::CAP_W){1'b0}}, capacity}) begin
          if (errors_o < 10)
            $display("capacity readback: expected %0d, got %h", capacity, prdata_i);
          errors_o++;
        end
      end
      if (rsp_i.valid && rsp_i.ready) begin
        case (rsp_i.kind)
          lfu_pkg::KIND_HIT:  hits_o++;
          lfu_pkg::KIND_FILL: fills_o++;
          lfu_pkg::KIND_WB:   writebacks_o++;
          default: ;
        endcase
        if (page_results_q.size() == 0) begin
          if (errors_o < 10)
            $display("unexpected item: kind %0d key %h slot %0d last %0d",
                     rsp_i.kind, rsp_i.out_key, rsp_i.slot, rsp_i.last);
          errors_o++;
        end else begin
          want = page_results_q.pop_front();
          if (rsp_i.kind !== want.kind || rsp_i.out_key !== want.key ||
              rsp_i.slot !== want.slot || rsp_i.last !== want.last) begin
            if (errors_o < 10)
              $display({"mismatch: expected kind %0d key %h slot %0d last %0d, ",
                        "got kind %0d key %h slot %0d last %0d"},
                       want.kind, want.key, want.slot, want.last,
                       rsp_i.kind, rsp_i.out_key, rsp_i.slot, rsp_i.last);
            errors_o++;
          end
        end
      end
      if (req_i.valid && req_i.ready)
        predict_directory(req_i.func, req_i.page_key, req_i.modify);
      pending_o <= page_results_q.size();
    end
  end

endmodule

`default_nettype wire

// ----- sim/lfu_page_cache_controller_unit_test.sv -----
`default_nettype none

module lfu_page_cache_controller_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WAYS        = 16;
  localparam int          CYCLE_LIMIT = 600000;
  localparam int          PHASE_ITEMS = 50;
  localparam logic [lfu_pkg::APB_ADDR_W-1:0] CAPACITY_ADDR = {lfu_pkg::REG_CAPACITY, 2'b00};

  logic                            clk_i;
  logic                            rst_ni;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [lfu_pkg::APB_ADDR_W-1:0]  paddr;
  logic [lfu_pkg::APB_DATA_W-1:0]  pwdata;
  logic [lfu_pkg::APB_DATA_W-1:0]  prdata;
  logic                            pready;

  int errors;
  int pending;
  int hits;
  int fills;
  int writebacks;
  int cycles;
  int accesses_sent;
  int syncs_sent;
  int capacity_writes;
  bit req_throttle;
  bit rsp_throttle;

  logic [lfu_pkg::KEY_W-1:0] key_pool[24];
  int                        pool_size;

  lfu_req_if req();
  lfu_rsp_if rsp();

  lfu_page_cache_controller_unit #(.WAYS(WAYS), .COUNT_BITS(16)) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .rsp_o   (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  lfu_page_cache_controller_unit_checker #(.WAYS(WAYS), .COUNT_BITS(16)) directory_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req),
    .rsp_i        (rsp),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .prdata_i     (prdata),
    .pready_i     (pready),
    .errors_o     (errors),
    .pending_o    (pending),
    .hits_o       (hits),
    .fills_o      (fills),
    .writebacks_o (writebacks)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  initial cycles = 0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: random stall before each item unless throttling is off
  initial begin
    int gap;
    rsp.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = rsp_throttle ? $urandom_range(0, 12) : 0;
      if (gap != 0) begin
        rsp.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk_i); while (!(rsp.valid && rsp.ready));
    end
  end

  task automatic send_item(input logic func, input logic [lfu_pkg::KEY_W-1:0] key,
                           input logic modify);
    int gap;
    gap = req_throttle ? $urandom_range(0, 12) : 0;
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid    <= 1'b1;
    req.func     <= func;
    req.page_key <= key;
    req.modify   <= modify;
    do @(posedge clk_i); while (!(req.valid && req.ready));
    if (func == lfu_pkg::FUNC_SYNC) syncs_sent++;
    else accesses_sent++;
  endtask

  task automatic wait_idle();
    req.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (WAYS + 8) @(posedge clk_i);
  endtask

  // write then read back; upper data bits are noise the register must drop
  task automatic write_capacity(input logic [lfu_pkg::CAP_W-1:0] value);
    logic [31:0] noise;
    noise   = $urandom();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAPACITY_ADDR;
    pwdata  <= {noise[31:lfu_pkg::CAP_W], value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    capacity_writes++;
  endtask

  function automatic logic [lfu_pkg::KEY_W-1:0] any_key();
    logic [31:0] r;
    r = $urandom();
    return r[lfu_pkg::KEY_W-1:0];
  endfunction

  task automatic run_phase(input logic [lfu_pkg::CAP_W-1:0] cap);
    int          slots;
    int          pick;
    logic [lfu_pkg::KEY_W-1:0] key;
    slots = (cap == 0) ? 1 : (cap > WAYS) ? WAYS : cap;
    pool_size = slots + $urandom_range(1, 6);
    for (int i = 0; i < pool_size; i++) key_pool[i] = any_key();
    if ($urandom_range(0, 1) == 1) begin
      key_pool[0] = '0;
      key_pool[1] = '1;
    end
    req_throttle = $urandom_range(0, 2) != 0;
    rsp_throttle = $urandom_range(0, 2) != 0;
    write_capacity(cap);
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
        send_item(lfu_pkg::FUNC_SYNC, any_key(), 1'($urandom_range(0, 1)));
      end else begin
        key = (pick < 4) ? any_key() : key_pool[$urandom_range(0, pool_size - 1)];
        send_item(lfu_pkg::FUNC_ACCESS, key, 1'($urandom_range(0, 1)));
      end
    end
    wait_idle();
  endtask

  initial begin
    logic [lfu_pkg::CAP_W-1:0] phase_caps[7];
    req.valid    = 1'b0;
    req.func     = lfu_pkg::FUNC_ACCESS;
    req.page_key = '0;
    req.modify   = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    rst_ni       = 1'b0;
    accesses_sent   = 0;
    syncs_sent      = 0;
    capacity_writes = 0;
    req_throttle    = 1'b1;
    rsp_throttle    = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset capacity: fill, dirty, hits, sync with and without dirty pages
    send_item(lfu_pkg::FUNC_ACCESS, 31'h0000_0000, 1'b0);
    send_item(lfu_pkg::FUNC_ACCESS, 31'h7FFF_FFFF, 1'b1);
    send_item(lfu_pkg::FUNC_ACCESS, 31'h0000_0000, 1'b1);
    send_item(lfu_pkg::FUNC_ACCESS, 31'h7FFF_FFFF, 1'b0);
    send_item(lfu_pkg::FUNC_SYNC,   31'h7FFF_FFFF, 1'b1);
    send_item(lfu_pkg::FUNC_SYNC,   31'h0000_0000, 1'b0);
    wait_idle();

    // capacity below occupancy, equal counts, dirty victim
    write_capacity(5'd1);
    send_item(lfu_pkg::FUNC_ACCESS, 31'h2AAA_AAAA, 1'b1);
    send_item(lfu_pkg::FUNC_ACCESS, 31'h5555_5555, 1'b0);
    send_item(lfu_pkg::FUNC_SYNC,   31'h1234_5678, 1'b0);
    wait_idle();

    // zero capacity acts as one
    write_capacity(5'd0);
    send_item(lfu_pkg::FUNC_ACCESS, 31'h0000_0001, 1'b1);
    send_item(lfu_pkg::FUNC_ACCESS, 31'h0000_0002, 1'b0);
    wait_idle();

    // capacity above the slot count: fill every slot, then evict
    write_capacity(5'd31);
    for (int i = 0; i < 15; i++)
      send_item(lfu_pkg::FUNC_ACCESS, 31'(100 + i), 1'(i % 2));
    wait_idle();

    phase_caps[0] = 5'd16;
    phase_caps[1] = 5'd1;
    phase_caps[2] = 5'd0;
    phase_caps[3] = 5'd31;
    phase_caps[4] = 5'($urandom_range(2, 15));
    phase_caps[5] = 5'($urandom_range(17, 30));
    phase_caps[6] = 5'($urandom_range(2, 8));
    for (int p = 0; p < 7; p++) run_phase(phase_caps[p]);

    $display("sent %0d accesses and %0d syncs across %0d capacity settings",
             accesses_sent, syncs_sent, capacity_writes);
    $display("saw %0d hits, %0d fills and %0d writebacks", hits, fills, writebacks);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
